/* sv/rid_pkg.sv */
// Shared types, codes and constants of the refractive index dispersion block.
`default_nettype none

package rid_pkg;

    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;
    localparam int MUL_LAT    = 4;
    localparam int FRONT_LAT  = 3;
    localparam int SUM_LAT    = 3;
    localparam int PIPE_LAT   = FRONT_LAT + DIV_STEPS + 3 * MUL_LAT + SUM_LAT + SQRT_STEPS + 1;

    localparam int NUM_COEFFS = 6;
    localparam int NUM_POLES  = 3;
    localparam int NUM_LANES  = 5;

    localparam logic [1:0] FS_SCHOTT = 2'd0;
    localparam logic [1:0] FS_SELL   = 2'd1;
    localparam logic [1:0] FS_FIXED  = 2'd2;
    localparam logic [1:0] FS_UNITY  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_MATH  = 2'd2;

    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORMULA     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COEFF_FIRST = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW      = 3'd7;

    localparam logic [63:0] WINDOW_RESET = 64'hFFFF_FFFF_0000_0000;
    localparam logic [63:0] PROD_CAP     = 64'h1000_0000_0000_0000;
    localparam logic [63:0] ONE_Q40      = 64'h0000_0100_0000_0000;
    localparam logic [63:0] INV_NUM_HI   = 64'h0000_0000_4000_0000;
    localparam logic [31:0] ONE_Q28      = 32'h1000_0000;
    localparam logic [31:0] INDEX_SAT    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic oow;
        logic inval;
    } t_side;

    typedef struct packed {
        logic [63:0] l2;
        logic [2:0]  dneg;
        t_side       sb;
    } t_b0;

    typedef struct packed {
        logic [2:0][63:0] q;
        logic [2:0]       qovf;
        logic [2:0]       dneg;
        logic [63:0]      l2;
        t_side            sb;
    } t_b1;

    typedef struct packed {
        t_b1         base;
        logic [63:0] inv4;
        logic        o4;
    } t_b2;

    typedef struct packed {
        logic [4:0] tneg;
        logic [4:0] tovf;
        t_side      sb;
    } t_b3;

    typedef struct packed {
        t_side sb;
        logic  neg;
        logic  big;
    } t_b4;

endpackage

`default_nettype wire

/* sv/rid_dly.sv */
// Fixed-length delay line that keeps side data aligned with the arithmetic units.
`default_nettype none

module rid_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_line [N];

    always_ff @(posedge i_clk) begin
        r_line[0] <= i_d;
        for (int i = 1; i < N; i++) begin
            r_line[i] <= r_line[i-1];
        end
    end

    assign o_q = r_line[N-1];

endmodule

`default_nettype wire

/* sv/rid_div.sv */
// Pipelined restoring divider: 128 by 64 bits to a 64-bit quotient, one bit per stage.
`default_nettype none

module rid_div (
    input  logic        i_clk,
    input  logic [63:0] i_hi,
    input  logic [63:0] i_lo,
    input  logic [63:0] i_den,
    output logic [63:0] o_quo,
    output logic        o_ovf
);

    localparam int N = rid_pkg::DIV_STEPS;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        logic        ovf;
    } t_dstate;

    function automatic t_dstate div_step(input t_dstate a);
        t_dstate    r;
        logic [64:0] t;
        logic [64:0] d;
        logic        ge;
        t     = {a.rem, a.num[63]};
        d     = t - {1'b0, a.den};
        ge    = t >= {1'b0, a.den};
        r     = a;
        r.rem = ge ? d[63:0] : t[63:0];
        r.num = {a.num[62:0], 1'b0};
        r.quo = {a.quo[62:0], ge};
        return r;
    endfunction

    t_dstate init;
    t_dstate r_st [N];

    // The quotient fits in 64 bits only when the upper numerator half is below the divisor.
    always_comb begin
        init.rem = i_hi;
        init.num = i_lo;
        init.den = i_den;
        init.quo = '0;
        init.ovf = i_hi >= i_den;
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= div_step(init);
        for (int s = 1; s < N; s++) begin
            r_st[s] <= div_step(r_st[s-1]);
        end
    end

    assign o_quo = r_st[N-1].quo;
    assign o_ovf = r_st[N-1].ovf;

endmodule

`default_nettype wire

/* sv/rid_mulq.sv */
// Four-stage 64 by 64 multiplier giving the product shifted right by 40 and an overflow flag.
`default_nettype none

module rid_mulq (
    input  logic        i_clk,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_res,
    output logic        o_ovf
);

    logic [63:0] r_p00, r_p01, r_p10, r_p11;
    logic [63:0] r_q00, r_q11;
    logic [64:0] r_mid;
    logic [64:0] r_lo;
    logic [63:0] r_hi;
    logic [63:0] hi_sum;
    logic [63:0] r_res;
    logic        r_ovf;

    assign hi_sum = r_hi + {63'd0, r_lo[64]};

    always_ff @(posedge i_clk) begin
        r_p00 <= i_a[31:0]  * i_b[31:0];
        r_p01 <= i_a[31:0]  * i_b[63:32];
        r_p10 <= i_a[63:32] * i_b[31:0];
        r_p11 <= i_a[63:32] * i_b[63:32];

        r_mid <= {1'b0, r_p01} + {1'b0, r_p10};
        r_q00 <= r_p00;
        r_q11 <= r_p11;

        r_lo  <= {1'b0, r_q00} + {1'b0, r_mid[31:0], 32'd0};
        r_hi  <= r_q11 + {31'd0, r_mid[64:32]};

        r_res <= {hi_sum[39:0], r_lo[63:40]};
        r_ovf <= hi_sum[63:40] != 24'd0;
    end

    assign o_res = r_res;
    assign o_ovf = r_ovf;

endmodule

`default_nettype wire

/* sv/rid_sqrt.sv */
// Pipelined integer square root of a 64-bit value, one result bit per stage.
`default_nettype none

module rid_sqrt (
    input  logic        i_clk,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    localparam int N = rid_pkg::SQRT_STEPS;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
    } t_sstate;

    function automatic t_sstate sqrt_step(input t_sstate a);
        t_sstate     r;
        logic [35:0] t;
        logic [35:0] trial;
        logic [35:0] d;
        logic        ge;
        t      = {a.rem, a.rad[63:62]};
        trial  = {2'b00, a.root, 2'b01};
        d      = t - trial;
        ge     = t >= trial;
        r.rem  = ge ? d[33:0] : t[33:0];
        r.root = {a.root[30:0], ge};
        r.rad  = {a.rad[61:0], 2'b00};
        return r;
    endfunction

    t_sstate init;
    t_sstate r_st [N];

    always_comb begin
        init.rem  = '0;
        init.root = '0;
        init.rad  = i_rad;
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= sqrt_step(init);
        for (int s = 1; s < N; s++) begin
            r_st[s] <= sqrt_step(r_st[s-1]);
        end
    end

    assign o_root = r_st[N-1].root;

endmodule

`default_nettype wire

/* sv/refractive_index_dispersion.sv */
// Top level: configuration registers and the full dispersion pipeline.
`default_nettype none

// Refractive index pipeline. One wavelength is accepted in every cycle (start while busy is
// low; busy is high only in reset) and its index and status appear with o_strobe at the end of the
// pipeline, which is built from the 64-stage divider that forms the inverse square or the
// Sellmeier ratios, three 4-stage multiplier layers, and the 32-stage square root.
// Results cannot be held off, so they must be taken in the cycle they are shown.
// Configuration writes are taken at any time outside reset but are meant for idle periods.
module refractive_index_dispersion #(
    parameter int COEFF_WIDTH = 48,
    parameter int WAVE_WIDTH  = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [WAVE_WIDTH-1:0]           i_wavelength_um,
    output logic                            o_strobe,
    output logic [31:0]                     o_refr_index,
    output logic [1:0]                      o_status,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rid_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [63:0]                     i_cfg_data
);

    localparam int NC = rid_pkg::NUM_COEFFS;
    localparam int NP = rid_pkg::NUM_POLES;
    localparam int NL = rid_pkg::NUM_LANES;
    localparam int LAT = rid_pkg::PIPE_LAT;

    // Configuration registers.
    logic [1:0]             r_formula;
    logic [COEFF_WIDTH-1:0] r_coeff [NC];
    logic [63:0]            r_window;

    logic [63:0] ksx    [NC];
    logic [63:0] kmag_c [NC];
    logic [63:0] r_kmag [NC];
    logic        r_kneg [NC];
    logic        r_kzero[NC];

    logic accept;
    logic [LAT-1:0] r_vld;

    assign busy        = ~i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_formula <= rid_pkg::FS_UNITY;
            r_window  <= rid_pkg::WINDOW_RESET;
            for (int i = 0; i < NC; i++) begin
                r_coeff[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rid_pkg::CFG_FORMULA: begin
                    r_formula <= i_cfg_data[1:0];
                end
                rid_pkg::CFG_WINDOW: begin
                    r_window <= i_cfg_data;
                end
                default: begin
                    r_coeff[rid_pkg::CFG_INDEX_W'(i_cfg_index - rid_pkg::CFG_COEFF_FIRST)]
                        <= i_cfg_data[COEFF_WIDTH-1:0];
                end
            endcase
        end
    end

    // Registered sign and magnitude of each coefficient; first read by stage 3.
    always_comb begin
        for (int i = 0; i < NC; i++) begin
            ksx[i]    = 64'($signed(r_coeff[i]));
            kmag_c[i] = ksx[i][63] ? (~ksx[i] + 64'd1) : ksx[i];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NC; i++) begin
            r_kmag[i]  <= kmag_c[i];
            r_kneg[i]  <= ksx[i][63];
            r_kzero[i] <= kmag_c[i] == 64'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    // Stage 1: input capture.
    logic [WAVE_WIDTH-1:0] r1_w;
    always_ff @(posedge i_clk) begin
        r1_w <= i_wavelength_um;
    end

    // Stage 2: square and window test.
    logic [2*WAVE_WIDTH-1:0] sq_c;
    logic [WAVE_WIDTH-1:0]   wmin, wmax;
    logic [63:0]             r2_sq;
    logic                    r2_oow, r2_wz;

    assign sq_c = r1_w * r1_w;
    assign wmin = r_window[WAVE_WIDTH-1:0];
    assign wmax = r_window[32 +: WAVE_WIDTH];

    always_ff @(posedge i_clk) begin
        r2_sq  <= 64'(sq_c);
        r2_oow <= (r1_w < wmin) || (r1_w > wmax);
        r2_wz  <= r1_w == '0;
    end

    // Stage 3: Sellmeier denominators and divider operands.
    logic [63:0] l2;
    logic [63:0] dmag   [NP];
    logic [NP-1:0] dneg_c, pole_c;
    logic [63:0] div_hi [NP];
    logic [63:0] div_lo [NP];
    logic [63:0] div_den[NP];
    logic [63:0] r3_hi  [NP];
    logic [63:0] r3_lo  [NP];
    logic [63:0] r3_den [NP];
    rid_pkg::t_b0 b0_c, r3_b0, b0_d;

    assign l2 = r2_sq >> 14;

    always_comb begin
        for (int t = 0; t < NP; t++) begin
            logic        pneg;
            logic [63:0] pmag;
            logic        le;
            pneg      = r_kneg[2*t+1];
            pmag      = r_kmag[2*t+1];
            le        = pmag <= l2;
            dmag[t]   = pneg ? (l2 + pmag) : (le ? (l2 - pmag) : (pmag - l2));
            dneg_c[t] = !pneg && !le;
            pole_c[t] = !pneg && (pmag == l2);
            div_hi[t]  = r2_sq >> 38;
            div_lo[t]  = r2_sq << 26;
            div_den[t] = dmag[t];
        end
        if (r_formula == rid_pkg::FS_SCHOTT) begin
            div_hi[0]  = rid_pkg::INV_NUM_HI;
            div_lo[0]  = '0;
            div_den[0] = r2_sq;
        end
        b0_c.l2     = l2;
        b0_c.dneg   = dneg_c;
        b0_c.sb.oow = r2_oow;
        unique case (r_formula)
            rid_pkg::FS_SCHOTT: b0_c.sb.inval = r2_wz;
            rid_pkg::FS_SELL:   b0_c.sb.inval = |pole_c;
            default:            b0_c.sb.inval = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r3_b0 <= b0_c;
        for (int t = 0; t < NP; t++) begin
            r3_hi[t]  <= div_hi[t];
            r3_lo[t]  <= div_lo[t];
            r3_den[t] <= div_den[t];
        end
    end

    // Dividers: inverse square for Schott in lane 0, one ratio per pole for Sellmeier.
    logic [63:0]   quo [NP];
    logic [NP-1:0] qovf;

    for (genvar t = 0; t < NP; t++) begin : g_div
        rid_div u_div (
            .i_clk (i_clk),
            .i_hi  (r3_hi[t]),
            .i_lo  (r3_lo[t]),
            .i_den (r3_den[t]),
            .o_quo (quo[t]),
            .o_ovf (qovf[t])
        );
    end

    rid_dly #(.W($bits(rid_pkg::t_b0)), .N(rid_pkg::DIV_STEPS)) u_dly0 (
        .i_clk (i_clk),
        .i_d   (r3_b0),
        .o_q   (b0_d)
    );

    // Multiplier layer 1: L^-4.
    rid_pkg::t_b1 b1_c, b1_d;
    logic [63:0]  inv4;
    logic         oa;

    always_comb begin
        for (int t = 0; t < NP; t++) begin
            b1_c.q[t] = quo[t];
        end
        b1_c.qovf = qovf;
        b1_c.dneg = b0_d.dneg;
        b1_c.l2   = b0_d.l2;
        b1_c.sb   = b0_d.sb;
    end

    rid_mulq u_mul_inv4 (
        .i_clk (i_clk),
        .i_a   (quo[0]),
        .i_b   (quo[0]),
        .o_res (inv4),
        .o_ovf (oa)
    );

    rid_dly #(.W($bits(rid_pkg::t_b1)), .N(rid_pkg::MUL_LAT)) u_dly1 (
        .i_clk (i_clk),
        .i_d   (b1_c),
        .o_q   (b1_d)
    );

    // Multiplier layer 2: L^-6 and L^-8.
    rid_pkg::t_b2 b2_c, b2_d;
    logic [63:0]  inv6, inv8;
    logic         ob, oc;

    always_comb begin
        b2_c.base = b1_d;
        b2_c.inv4 = inv4;
        b2_c.o4   = b1_d.qovf[0] || oa;
    end

    rid_mulq u_mul_inv6 (
        .i_clk (i_clk),
        .i_a   (inv4),
        .i_b   (b1_d.q[0]),
        .o_res (inv6),
        .o_ovf (ob)
    );

    rid_mulq u_mul_inv8 (
        .i_clk (i_clk),
        .i_a   (inv4),
        .i_b   (inv4),
        .o_res (inv8),
        .o_ovf (oc)
    );

    rid_dly #(.W($bits(rid_pkg::t_b2)), .N(rid_pkg::MUL_LAT)) u_dly2 (
        .i_clk (i_clk),
        .i_d   (b2_c),
        .o_q   (b2_d)
    );

    // Multiplier layer 3: coefficient times term, five lanes.
    logic [2:0]    lane_idx [NL];
    logic [NL-1:0] lane_on;
    logic [63:0]   tmag [NL];
    logic [NL-1:0] tneg, tovf;
    logic [63:0]   prod [NL];
    logic [NL-1:0] povf;
    rid_pkg::t_b3  b3_c, b3_d;

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            lane_idx[l] = 3'd0;
            lane_on[l]  = 1'b0;
            tmag[l]     = '0;
            tneg[l]     = 1'b0;
            tovf[l]     = 1'b0;
            unique case (r_formula)
                rid_pkg::FS_SCHOTT: begin
                    lane_idx[l] = 3'(l + 1);
                    lane_on[l]  = 1'b1;
                end
                rid_pkg::FS_SELL: begin
                    if (l < NP) begin
                        lane_idx[l] = 3'(2 * l);
                        lane_on[l]  = 1'b1;
                        tmag[l]     = b2_d.base.q[l];
                        tneg[l]     = b2_d.base.dneg[l];
                        tovf[l]     = b2_d.base.qovf[l];
                    end
                end
                default: begin
                end
            endcase
        end
        if (r_formula == rid_pkg::FS_SCHOTT) begin
            tmag[0] = b2_d.base.l2;
            tmag[1] = b2_d.base.q[0];
            tmag[2] = b2_d.inv4;
            tmag[3] = inv6;
            tmag[4] = inv8;
            tovf[1] = b2_d.base.qovf[0];
            tovf[2] = b2_d.o4;
            tovf[3] = b2_d.o4 || ob;
            tovf[4] = b2_d.o4 || oc;
        end
        b3_c.tneg = tneg;
        b3_c.tovf = tovf;
        b3_c.sb   = b2_d.base.sb;
    end

    for (genvar l = 0; l < NL; l++) begin : g_term
        rid_mulq u_mul_term (
            .i_clk (i_clk),
            .i_a   (r_kmag[lane_idx[l]]),
            .i_b   (tmag[l]),
            .o_res (prod[l]),
            .o_ovf (povf[l])
        );
    end

    rid_dly #(.W($bits(rid_pkg::t_b3)), .N(rid_pkg::MUL_LAT)) u_dly3 (
        .i_clk (i_clk),
        .i_d   (b3_c),
        .o_q   (b3_d)
    );

    // Sum stages: clamp and sign each term, then add in two levels.
    logic [63:0] val_c [NL];
    logic [63:0] base_c, k0cap;
    logic [63:0] r_v [NL];
    logic [63:0] r_base;
    logic [63:0] r_s0, r_s1, r_s2, r_rad;
    rid_pkg::t_side r_sb1, r_sb2, r_sb3;

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            logic [63:0] mag;
            logic        neg;
            mag = (b3_d.tovf[l] || povf[l] || (prod[l] > rid_pkg::PROD_CAP))
                  ? rid_pkg::PROD_CAP : prod[l];
            if (!lane_on[l] || r_kzero[lane_idx[l]]) begin
                mag = '0;
            end
            neg      = r_kneg[lane_idx[l]] ^ b3_d.tneg[l];
            val_c[l] = neg ? (~mag + 64'd1) : mag;
        end
        k0cap = (r_kmag[0] > rid_pkg::PROD_CAP) ? rid_pkg::PROD_CAP : r_kmag[0];
        unique case (r_formula)
            rid_pkg::FS_SCHOTT: base_c = r_kneg[0] ? (~k0cap + 64'd1) : k0cap;
            rid_pkg::FS_SELL:   base_c = rid_pkg::ONE_Q40;
            default:            base_c = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NL; l++) begin
            r_v[l] <= val_c[l];
        end
        r_base <= base_c;
        r_sb1  <= b3_d.sb;

        r_s0  <= r_base + r_v[0];
        r_s1  <= r_v[1] + r_v[2];
        r_s2  <= r_v[3] + r_v[4];
        r_sb2 <= r_sb1;

        r_rad <= r_s0 + r_s1 + r_s2;
        r_sb3 <= r_sb2;
    end

    // Square root of the radicand scaled from Q40 to Q56.
    rid_pkg::t_b4 b4_c, b4_d;
    logic [31:0]  root;

    always_comb begin
        b4_c.sb  = r_sb3;
        b4_c.neg = r_rad[63];
        b4_c.big = !r_rad[63] && (r_rad[62:48] != 15'd0);
    end

    rid_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rad  ({r_rad[47:0], 16'd0}),
        .o_root (root)
    );

    rid_dly #(.W($bits(rid_pkg::t_b4)), .N(rid_pkg::SQRT_STEPS)) u_dly4 (
        .i_clk (i_clk),
        .i_d   (b4_c),
        .o_q   (b4_d)
    );

    // Output stage.
    logic        is_root;
    logic [1:0]  status_c;
    logic [31:0] index_c;
    logic [31:0] r_index;
    logic [1:0]  r_status;

    assign is_root = (r_formula == rid_pkg::FS_SCHOTT) || (r_formula == rid_pkg::FS_SELL);

    always_comb begin
        if (b4_d.sb.oow) begin
            status_c = rid_pkg::ST_RANGE;
        end else if (is_root && (b4_d.sb.inval || b4_d.neg)) begin
            status_c = rid_pkg::ST_MATH;
        end else begin
            status_c = rid_pkg::ST_OK;
        end
        unique case (r_formula)
            rid_pkg::FS_SCHOTT,
            rid_pkg::FS_SELL: begin
                index_c = b4_d.big ? rid_pkg::INDEX_SAT : root;
            end
            rid_pkg::FS_FIXED: begin
                if (r_kneg[0]) begin
                    index_c = '0;
                end else if (r_kmag[0][63:44] != 20'd0) begin
                    index_c = rid_pkg::INDEX_SAT;
                end else begin
                    index_c = r_kmag[0][43:12];
                end
            end
            default: begin
                index_c = rid_pkg::ONE_Q28;
            end
        endcase
        if (status_c != rid_pkg::ST_OK) begin
            index_c = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_index  <= index_c;
        r_status <= status_c;
    end

    assign o_strobe     = r_vld[LAT-1];
    assign o_refr_index = r_index;
    assign o_status     = r_status;

endmodule

`default_nettype wire

/* sv/rid_chk.sv */
// Port-level checker for the refractive index pipeline and its bind to the top level.
`default_nettype none

module rid_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [31:0] o_refr_index,
    input logic [1:0]  o_status
);

    localparam int LAT = rid_pkg::PIPE_LAT;

    // Every accepted item comes out after the fixed latency.
    a_latency_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("accepted item did not come out after the pipeline latency");

    // No result appears without an item accepted the latency earlier.
    a_latency_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result without a matching accepted item");

    // An error status always carries a zero index.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != rid_pkg::ST_OK)) |-> (o_refr_index == 32'd0))
        else $error("error status with a nonzero index");

    // Reset flushes every item in flight.
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result shown right after reset");

endmodule

bind refractive_index_dispersion rid_chk u_rid_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_refr_index (o_refr_index),
    .o_status     (o_status)
);

`default_nettype wire
